// ===== sv/twc_pkg.sv =====
package twc_pkg;

	typedef enum logic [2:0] {
		OP_CONTROL  = 3'd0,
		OP_TIMER_LO = 3'd1,
		OP_LEN_HI   = 3'd2,
		OP_ENABLE   = 3'd3,
		OP_TIMER    = 3'd4,
		OP_QUARTER  = 3'd5,
		OP_HALF     = 3'd6
	} op_t;

	typedef struct packed {
		logic [3:0] sample;
		logic       length_active;
	} result_t;

	localparam logic [10:0] MIN_PERIOD = 11'd3;

	localparam logic [3:0] TRI_LEVELS [0:31] = '{
		4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
		4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
	};

	localparam logic [7:0] LEN_LOADS [0:31] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

endpackage

// ===== sv/twc_core.sv =====
module twc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [2:0]           opcode,
	input  logic [7:0]           data,
	output twc_pkg::result_t     result
);

	logic [10:0] period_q, period_n;
	logic [10:0] count_q, count_n;
	logic [7:0]  len_q, len_n;
	logic [6:0]  lin_reload_q, lin_reload_n;
	logic [6:0]  lin_q, lin_n;
	logic        reload_q, reload_n;
	logic        len_on_q, len_on_n;
	logic        on_q, on_n;
	logic [4:0]  step_q, step_n;

	always_comb begin
		period_n     = period_q;
		count_n      = count_q;
		len_n        = len_q;
		lin_reload_n = lin_reload_q;
		lin_n        = lin_q;
		reload_n     = reload_q;
		len_on_n     = len_on_q;
		on_n         = on_q;
		step_n       = step_q;
		unique case (twc_pkg::op_t'(opcode))
			twc_pkg::OP_CONTROL: begin
				lin_reload_n = data[6:0];
				len_on_n     = !data[7];
			end
			twc_pkg::OP_TIMER_LO: begin
				period_n = {period_q[10:8], data};
			end
			twc_pkg::OP_LEN_HI: begin
				period_n = {data[2:0], period_q[7:0]};
				count_n  = {data[2:0], period_q[7:0]};
				len_n    = twc_pkg::LEN_LOADS[data[7:3]];
				reload_n = 1'b1;
			end
			twc_pkg::OP_ENABLE: begin
				on_n = |data;
				if (~|data) begin
					len_n = 8'd0;
				end
			end
			twc_pkg::OP_TIMER: begin
				if (count_q == 11'd0) begin
					count_n = period_q;
					if (len_q != 8'd0 && lin_q != 7'd0) begin
						step_n = step_q + 5'd1;
					end
				end else begin
					count_n = count_q - 11'd1;
				end
			end
			twc_pkg::OP_QUARTER: begin
				if (reload_q) begin
					lin_n = lin_reload_q;
				end else if (lin_q != 7'd0) begin
					lin_n = lin_q - 7'd1;
				end
				if (len_on_q) begin
					reload_n = 1'b0;
				end
			end
			twc_pkg::OP_HALF: begin
				if (len_on_q && len_q != 8'd0) begin
					len_n = len_q - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Report from the state as it stands after this transfer
	always_comb begin
		result.length_active = (len_n != 8'd0);
		if (on_n && period_n >= twc_pkg::MIN_PERIOD && len_n != 8'd0 && lin_n != 7'd0) begin
			result.sample = twc_pkg::TRI_LEVELS[step_n];
		end else begin
			result.sample = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= '0;
			count_q      <= '0;
			len_q        <= '0;
			lin_reload_q <= '0;
			lin_q        <= '0;
			reload_q     <= 1'b0;
			len_on_q     <= 1'b0;
			on_q         <= 1'b0;
			step_q       <= '0;
		end else if (advance) begin
			period_q     <= period_n;
			count_q      <= count_n;
			len_q        <= len_n;
			lin_reload_q <= lin_reload_n;
			lin_q        <= lin_n;
			reload_q     <= reload_n;
			len_on_q     <= len_on_n;
			on_q         <= on_n;
			step_q       <= step_n;
		end
	end

endmodule

// ===== sv/triangle_wave_channel.sv =====
// Triangle-wave sound channel. Every input transfer (a register write or a
// timer, quarter-frame or half-frame tick) yields exactly one result transfer
// carrying the 4-bit sample and the length-active flag as they stand after
// that item. One item is taken every cycle while the output side keeps up;
// each item passes from an input register through the channel state update
// into the result register. When the output is stalled, one item is held in
// the input register and one in the result register before in_stall rises.
module triangle_wave_channel (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] sample,
	output logic       length_active
);

	logic              valid_s1;
	logic [2:0]        opcode_s1;
	logic [7:0]        data_s1;
	logic              valid_s2;
	twc_pkg::result_t  result_s2;
	twc_pkg::result_t  result_next;
	logic              s2_free;
	logic              s1_free;
	logic              advance;

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_free  = !valid_s1 || s2_free;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = !s1_free;

	twc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.opcode (opcode_s1),
		.data   (data_s1),
		.result (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: hold while the stage is occupied and blocked
	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			opcode_s1 <= opcode;
			data_s1   <= data;
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid     = valid_s2;
	assign sample        = result_s2.sample;
	assign length_active = result_s2.length_active;

endmodule

// ===== sv/twc_checker.sv =====
module twc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] opcode,
	input logic [7:0] data,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] sample,
	input logic       length_active
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(length_active))
		else $error("result changed while stalled");

	// A nonzero level needs a running length counter
	a_level_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample != 4'd0 |-> length_active)
		else $error("sample nonzero with length counter at zero");

	// Back-pressure only comes from a stalled, full output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side is free");

	// A disabling enable write shows a cleared length flag at the output
	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == twc_pkg::OP_ENABLE && data == 8'd0
			&& !(out_valid && out_stall) ##1 !out_stall
		|=> out_valid && !length_active)
		else $error("length flag still set after disable");

endmodule

bind triangle_wave_channel twc_checker u_twc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.opcode       (opcode),
	.data         (data),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample       (sample),
	.length_active(length_active)
);

// ===== tb/tb_top.sv =====
module tb_top;

	localparam logic [2:0]  OP_SPARE    = 3'd7;
	localparam logic [10:0] MUTE_BELOW  = 11'd3;
	localparam int          RANDOM_ITEMS = 650;

	localparam logic [7:0] LEN_TABLE [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	typedef struct {
		logic [2:0] op;
		logic [7:0] arg;
		int         gap;
	} stim_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] opcode = '0;
	logic [7:0] data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] sample;
	logic       length_active;

	// channel state as predicted
	logic [10:0] period = '0;
	logic [10:0] tmr = '0;
	logic [7:0]  len_cnt = '0;
	logic [6:0]  lin_reload = '0;
	logic [6:0]  lin_cnt = '0;
	logic        lin_reload_flag = 1'b0;
	logic        len_run = 1'b0;
	logic        chan_on = 1'b0;
	logic [4:0]  phase = '0;

	stim_t            stim_items[$];
	twc_pkg::result_t level_queue[$];
	bit      tx_burst = 1'b0;
	int      rx_hold = 0;
	int      queued = 0;
	int      items_in = 0;
	int      results_seen = 0;
	int      audible = 0;
	int      steps = 0;
	int      errors = 0;

	triangle_wave_channel uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.data         (data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.length_active(length_active)
	);

	always #4 clk = ~clk;

	task automatic step_channel(input logic [2:0] op, input logic [7:0] d,
		output twc_pkg::result_t r);
		case (op)
			twc_pkg::OP_CONTROL: begin
				lin_reload = d[6:0];
				len_run = ~d[7];
			end
			twc_pkg::OP_TIMER_LO: period[7:0] = d;
			twc_pkg::OP_LEN_HI: begin
				period[10:8] = d[2:0];
				tmr = period;
				len_cnt = LEN_TABLE[d[7:3]];
				lin_reload_flag = 1'b1;
			end
			twc_pkg::OP_ENABLE: begin
				chan_on = (d != 8'd0);
				if (d == 8'd0)
					len_cnt = '0;
			end
			twc_pkg::OP_TIMER: begin
				if (tmr == '0) begin
					tmr = period;
					if (len_cnt != '0 && lin_cnt != '0) begin
						phase = phase + 5'd1;
						steps++;
					end
				end else begin
					tmr = tmr - 11'd1;
				end
			end
			twc_pkg::OP_QUARTER: begin
				if (lin_reload_flag)
					lin_cnt = lin_reload;
				else if (lin_cnt != '0)
					lin_cnt = lin_cnt - 7'd1;
				// a halted length counter keeps the reload flag set
				if (len_run)
					lin_reload_flag = 1'b0;
			end
			twc_pkg::OP_HALF: begin
				if (len_run && len_cnt != '0)
					len_cnt = len_cnt - 8'd1;
			end
			default: ;
		endcase
		r.length_active = (len_cnt != '0);
		if (!chan_on || period < MUTE_BELOW || len_cnt == '0 || lin_cnt == '0)
			r.sample = 4'd0;
		else
			r.sample = phase[4] ? phase[3:0] : ~phase[3:0];
	endtask

	task automatic queue_item(input logic [2:0] op, input logic [7:0] d);
		stim_t it;
		it.op = op;
		it.arg = d;
		it.gap = tx_burst ? 0 : $urandom_range(0, 6);
		stim_items.push_back(it);
		queued++;
	endtask

	// one note: set the channel up, then mostly timer ticks with frame ticks mixed in
	task automatic queue_note();
		int n;
		int k;
		tx_burst = ($urandom_range(0, 2) == 0);
		queue_item(twc_pkg::OP_ENABLE,
			($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
		queue_item(twc_pkg::OP_CONTROL, {($urandom_range(0, 3) == 0),
			($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12))});
		queue_item(twc_pkg::OP_TIMER_LO,
			($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9)));
		queue_item(twc_pkg::OP_LEN_HI,
			{5'($urandom), ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'd0});
		queue_item(twc_pkg::OP_QUARTER, 8'($urandom));
		n = $urandom_range(10, 40);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k < 7)
				queue_item(twc_pkg::OP_TIMER, 8'($urandom));
			else if (k < 9)
				queue_item(twc_pkg::OP_QUARTER, 8'($urandom));
			else
				queue_item(twc_pkg::OP_HALF, 8'($urandom));
		end
	endtask

	// sender: present the next item once its gap has run out
	always @(posedge clk or negedge arst_n) begin : driver
		twc_pkg::result_t r;
		stim_t   it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			data <= '0;
			period = '0;
			tmr = '0;
			len_cnt = '0;
			lin_reload = '0;
			lin_cnt = '0;
			lin_reload_flag = 1'b0;
			len_run = 1'b0;
			chan_on = 1'b0;
			phase = '0;
		end else begin
			if (in_valid && !in_stall) begin
				step_channel(opcode, data, r);
				level_queue.push_back(r);
				items_in++;
				if (r.sample != 4'd0)
					audible++;
			end
			if (!in_valid || !in_stall) begin
				if (stim_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (stim_items[0].gap != 0) begin
					stim_items[0].gap = stim_items[0].gap - 1;
					in_valid <= 1'b0;
				end else begin
					it = stim_items.pop_front();
					in_valid <= 1'b1;
					opcode <= it.op;
					data <= it.arg;
				end
			end
		end
	end

	// receiver: check each transfer, then hold off for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin : monitor
		twc_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (level_queue.size() == 0) begin
					$display("%0t: result with nothing expected: sample %0d length_active %0b",
						$time, sample, length_active);
					errors++;
				end else begin
					want = level_queue.pop_front();
					if (sample !== want.sample) begin
						$display("%0t: sample expected %0d got %0d", $time, want.sample, sample);
						errors++;
					end
					if (length_active !== want.length_active) begin
						$display("%0t: length_active expected %0b got %0b",
							$time, want.length_active, length_active);
						errors++;
					end
				end
				results_seen++;
				if (results_seen == 120 || results_seen == 450)
					rx_hold = 90;
				else if (results_seen % 150 < 40)
					rx_hold = 0;
				else
					rx_hold = $urandom_range(0, 6);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			out_stall <= (rx_hold != 0);
		end
	end

	initial begin : stimulus
		int base;
		queue_item(OP_SPARE, 8'h00);
		queue_item(twc_pkg::OP_LEN_HI, 8'hF8);
		queue_item(twc_pkg::OP_ENABLE, 8'h00);
		queue_item(twc_pkg::OP_HALF, 8'h00);
		queue_item(twc_pkg::OP_ENABLE, 8'h01);
		queue_item(twc_pkg::OP_CONTROL, 8'hFF);
		queue_item(twc_pkg::OP_TIMER_LO, 8'h02);
		queue_item(twc_pkg::OP_LEN_HI, 8'h08);
		queue_item(twc_pkg::OP_QUARTER, 8'h00);
		// period below three: the sequence runs but stays silent
		queue_item(twc_pkg::OP_TIMER, 8'h00);
		queue_item(twc_pkg::OP_TIMER, 8'hFF);
		queue_item(twc_pkg::OP_TIMER, 8'h00);
		queue_item(twc_pkg::OP_TIMER_LO, 8'h03);
		queue_item(twc_pkg::OP_HALF, 8'h00);
		queue_item(twc_pkg::OP_CONTROL, 8'h00);
		queue_item(twc_pkg::OP_QUARTER, 8'h00);
		queue_item(twc_pkg::OP_QUARTER, 8'h00);
		queue_item(twc_pkg::OP_LEN_HI, 8'h1F);
		queue_item(twc_pkg::OP_HALF, 8'h00);
		queue_item(twc_pkg::OP_HALF, 8'h00);
		queue_item(twc_pkg::OP_HALF, 8'hFF);
		queue_item(twc_pkg::OP_TIMER, 8'hAA);
		queue_item(twc_pkg::OP_ENABLE, 8'h80);
		queue_item(twc_pkg::OP_TIMER_LO, 8'h00);
		queue_item(OP_SPARE, 8'hFF);
		base = queued;
		while (queued - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				queue_note();
			end else begin
				tx_burst = 1'b0;
				repeat ($urandom_range(1, 8))
					queue_item(3'($urandom_range(0, 7)), 8'($urandom));
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// sample the drain condition away from the driving edge
		while (stim_items.size() != 0 || in_valid || level_queue.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		$display("%0d items sent, %0d results checked (%0d audible), %0d triangle steps taken",
			items_in, results_seen, audible, steps);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("timeout: %0d results still outstanding", level_queue.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
